// ===== rtl/hsba_pkg.sv =====
// Shared constants and types for the hashed segment bump allocator.
package hsba_pkg;

    // Default configuration of the allocator.
    localparam int HSBA_SEGMENTS      = 16;
    localparam int HSBA_SEGMENT_BYTES = 1048576;
    localparam int HSBA_PROBES        = 3;

    // Fixed field widths of the request and response ports.
    localparam int HSBA_SIZE_W = 21;
    localparam int HSBA_HASH_W = 32;
    localparam int HSBA_IDX_W  = 4;
    localparam int HSBA_OFF_W  = 20;

    // Control that travels with a request from the hash stages to the allocation stage.
    typedef struct packed {
        logic valid;
        logic too_large;
    } t_ctl;

endpackage

// ===== rtl/hsba_home.sv =====
// Two-stage reduction of the request hash to a home segment, plus the size check.
module hsba_home
    import hsba_pkg::*;
#(
    parameter int SEGMENTS      = HSBA_SEGMENTS,
    parameter int SEGMENT_BYTES = HSBA_SEGMENT_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic                         i_valid,
    input  logic [HSBA_SIZE_W-1:0]       i_request_size,
    input  logic [HSBA_HASH_W-1:0]       i_hash,
    output t_ctl                         o_ctl,
    output logic [$clog2(SEGMENTS)-1:0]  o_home,
    output logic [HSBA_SIZE_W-1:0]       o_request_size
);

    localparam int IW = $clog2(SEGMENTS);
    localparam int FW = $clog2(SEGMENT_BYTES + 1);
    localparam int CW = (FW > HSBA_SIZE_W) ? FW : HSBA_SIZE_W;
    // Truncated reciprocal; the estimated quotient is exact or one too small.
    localparam logic [HSBA_HASH_W-1:0] HASH_RECIP =
        HSBA_HASH_W'(64'd4294967296 / 64'(SEGMENTS));

    logic                     r_a_valid;
    logic [HSBA_HASH_W-1:0]   r_a_quot;
    logic [HSBA_HASH_W-1:0]   r_a_hash;
    logic [HSBA_SIZE_W-1:0]   r_a_size;
    logic [63:0]              w_prod;
    logic [HSBA_HASH_W:0]     w_rem;
    logic [HSBA_HASH_W:0]     w_rem_fix;
    t_ctl                     n_ctl;
    t_ctl                     r_ctl;
    logic [IW-1:0]            r_home;
    logic [HSBA_SIZE_W-1:0]   r_size;

    // First stage: estimate the quotient of the hash by the segment count.
    assign w_prod = 64'(i_hash) * 64'(HASH_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_advance) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_a_quot <= w_prod[63:32];
            r_a_hash <= i_hash;
            r_a_size <= i_request_size;
        end
    end

    // Second stage: remainder with one correction step, and the oversize check.
    assign w_rem = (HSBA_HASH_W + 1)'(r_a_hash)
                 - ((HSBA_HASH_W + 1)'(r_a_quot) * (HSBA_HASH_W + 1)'(SEGMENTS));
    assign w_rem_fix = (w_rem >= (HSBA_HASH_W + 1)'(SEGMENTS))
                     ? w_rem - (HSBA_HASH_W + 1)'(SEGMENTS) : w_rem;

    always_comb begin
        n_ctl.valid     = r_a_valid;
        n_ctl.too_large = CW'(r_a_size) > CW'(SEGMENT_BYTES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_advance) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_home <= w_rem_fix[IW-1:0];
            r_size <= r_a_size;
        end
    end

    assign o_ctl          = r_ctl;
    assign o_home         = r_home;
    assign o_request_size = r_size;

endmodule

// ===== rtl/hashed_segment_bump_allocator.sv =====
// Top level of the hashed segment bump allocator.
// Usage: a request transaction carries a byte size and a key hash on the input
// channel (i_valid / o_stall); the response transaction carries the segment index,
// the byte offset in that segment, a reclaimed flag and a too-large flag on the
// output channel (o_valid / i_stall). Every request gives exactly one response.
// The hash modulo the segment count picks a home segment. The home segment and
// the next PROBES segments (wrapping) are tried in order; the first with room
// is bumped. If none has room, the home segment restarts at the request size.
// A request larger than a segment is flagged and changes nothing.
// A multiply stage and a correction stage reduce the hash, then a last stage
// reads and updates the fill table and loads the response register. One request
// is accepted per cycle while o_stall is low; back-to-back requests see each
// other's updates because the table is only read and written in that last stage.
// Synchronous reset clears the fill table and all valid flags.
// When the receiver stalls a waiting response, the whole pipeline holds and
// o_stall rises in the same cycle, so no transaction is dropped.
module hashed_segment_bump_allocator
    import hsba_pkg::*;
#(
    parameter int SEGMENTS      = HSBA_SEGMENTS,
    parameter int SEGMENT_BYTES = HSBA_SEGMENT_BYTES,
    parameter int PROBES        = HSBA_PROBES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [HSBA_SIZE_W-1:0]  i_request_size,
    input  logic [HSBA_HASH_W-1:0]  i_hash,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [HSBA_IDX_W-1:0]   o_segment_index,
    output logic [HSBA_OFF_W-1:0]   o_offset,
    output logic                    o_reclaimed,
    output logic                    o_too_large
);

    localparam int IW = $clog2(SEGMENTS);
    localparam int FW = $clog2(SEGMENT_BYTES + 1);
    localparam int CW = (FW > HSBA_SIZE_W) ? FW : HSBA_SIZE_W;
    localparam int PW = $clog2(PROBES + 1);

    logic                    w_advance;
    t_ctl                    w_ctl;
    logic [IW-1:0]           w_home;
    logic [HSBA_SIZE_W-1:0]  w_size;
    logic [FW-1:0]           r_fill [SEGMENTS];
    logic [IW-1:0]           w_cand [PROBES+1];
    logic [FW-1:0]           w_pos  [PROBES+1];
    logic [PROBES:0]         w_fit;
    logic                    w_hit;
    logic [PW-1:0]           w_pick;
    logic [IW-1:0]           w_seg;
    logic [FW-1:0]           w_off;
    logic [FW-1:0]           w_fill_new;
    logic [IW+HSBA_IDX_W-1:0] w_seg_pad;
    logic [FW+HSBA_OFF_W-1:0] w_off_pad;
    logic                    w_commit;
    logic                    r_out_valid;
    logic [HSBA_IDX_W-1:0]   r_seg;
    logic [HSBA_OFF_W-1:0]   r_off;
    logic                    r_reclaimed;
    logic                    r_too_large;

    // The pipeline moves whenever the response register is free or being taken.
    assign w_advance = !r_out_valid || !i_stall;
    assign o_stall   = !w_advance;

    hsba_home #(
        .SEGMENTS      (SEGMENTS),
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_home (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_valid        (i_valid),
        .i_request_size (i_request_size),
        .i_hash         (i_hash),
        .o_ctl          (w_ctl),
        .o_home         (w_home),
        .o_request_size (w_size)
    );

    // Candidate segments: the home segment and its wrapping neighbors.
    for (genvar k = 0; k <= PROBES; k++) begin : g_probe
        localparam int STEP = k % SEGMENTS;
        logic [IW:0] sum;
        assign sum = (IW + 1)'(w_home) + (IW + 1)'(STEP);
        assign w_cand[k] = (sum >= (IW + 1)'(SEGMENTS))
                         ? IW'(sum - (IW + 1)'(SEGMENTS)) : IW'(sum);
        assign w_pos[k] = r_fill[w_cand[k]];
        assign w_fit[k] = (CW'(SEGMENT_BYTES) - CW'(w_pos[k])) >= CW'(w_size);
    end

    // The first candidate with room wins.
    always_comb begin
        w_hit  = 1'b0;
        w_pick = '0;
        for (int k = PROBES; k >= 0; k--) begin
            if (w_fit[k]) begin
                w_hit  = 1'b1;
                w_pick = PW'(k);
            end
        end
    end

    // Placement, or a restart of the home segment when nothing fits.
    always_comb begin
        if (w_hit) begin
            w_seg      = w_cand[w_pick];
            w_off      = w_pos[w_pick];
            w_fill_new = FW'(CW'(w_pos[w_pick]) + CW'(w_size));
        end else begin
            w_seg      = w_home;
            w_off      = '0;
            w_fill_new = FW'(w_size);
        end
    end

    assign w_seg_pad = (IW + HSBA_IDX_W)'(w_seg);
    assign w_off_pad = (FW + HSBA_OFF_W)'(w_off);
    assign w_commit  = w_advance && w_ctl.valid;

    // Fill table update for every request that is not oversized.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SEGMENTS; s++) begin
                r_fill[s] <= '0;
            end
        end else if (w_commit && !w_ctl.too_large) begin
            r_fill[w_seg] <= w_fill_new;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            if (w_ctl.too_large) begin
                r_seg       <= '0;
                r_off       <= '0;
                r_reclaimed <= 1'b0;
                r_too_large <= 1'b1;
            end else begin
                r_seg       <= w_seg_pad[HSBA_IDX_W-1:0];
                r_off       <= w_off_pad[HSBA_OFF_W-1:0];
                r_reclaimed <= !w_hit;
                r_too_large <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_segment_index = r_seg;
    assign o_offset        = r_off;
    assign o_reclaimed     = r_reclaimed;
    assign o_too_large     = r_too_large;

endmodule

// ===== rtl/hsba_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
module hsba_checker
    import hsba_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_stall,
    input  logic                    o_valid,
    input  logic                    i_stall,
    input  logic [HSBA_IDX_W-1:0]   o_segment_index,
    input  logic [HSBA_OFF_W-1:0]   o_offset,
    input  logic                    o_reclaimed,
    input  logic                    o_too_large
);

    // A stalled response transaction stays valid.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("response dropped while stalled");

    // A stalled response transaction keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_segment_index) && $stable(o_offset)
            && $stable(o_reclaimed) && $stable(o_too_large))
        else $error("response payload changed while stalled");

    // The block only pushes back when a finished response is held up.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled without a blocked response");

    // An oversized request allocates nothing.
    a_too_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_large |-> o_segment_index == '0 && o_offset == '0
            && !o_reclaimed)
        else $error("oversized request reported an allocation");

    // A restarted segment always hands out its first byte.
    a_reclaim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reclaimed |-> o_offset == '0 && !o_too_large)
        else $error("reclaimed allocation not at offset zero");

endmodule

bind hashed_segment_bump_allocator hsba_checker u_hsba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_segment_index (o_segment_index),
    .o_offset        (o_offset),
    .o_reclaimed     (o_reclaimed),
    .o_too_large     (o_too_large)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the hashed segment bump allocator.
`timescale 1ns / 1ps

module tb_top;
    import hsba_pkg::*;

    localparam int SEGS           = HSBA_SEGMENTS;
    localparam int SEG_BYTES      = HSBA_SEGMENT_BYTES;
    localparam int NUM_PROBES     = HSBA_PROBES;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int MAX_PRINTS     = 40;

    // One allocation response, as the block reports it.
    typedef struct packed {
        logic [HSBA_IDX_W-1:0] segment_index;
        logic [HSBA_OFF_W-1:0] offset;
        logic                  reclaimed;
        logic                  too_large;
    } t_alloc_resp;

    // Receiver back-pressure patterns.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [HSBA_SIZE_W-1:0] i_request_size;
    logic [HSBA_HASH_W-1:0] i_hash;
    logic                   o_valid;
    logic                   i_stall;
    logic [HSBA_IDX_W-1:0]  o_segment_index;
    logic [HSBA_OFF_W-1:0]  o_offset;
    logic                   o_reclaimed;
    logic                   o_too_large;

    // Predicted fill position of every segment.
    logic [HSBA_SIZE_W-1:0] fill_level [SEGS];
    // Responses predicted for accepted requests, oldest first.
    t_alloc_resp            pending_allocs [$];

    int          error_count;
    int          checked_count;
    int          cycle_count;
    int          neighbor_count;
    int          reclaim_count;
    int          oversize_count;
    int          zero_size_count;
    t_stall_mode stall_mode;
    int          mode_left;
    int          holdoff_left;
    bit          holdoff_request;
    bit          drain_flush;

    hashed_segment_bump_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_request_size  (i_request_size),
        .i_hash          (i_hash),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_segment_index (o_segment_index),
        .o_offset        (o_offset),
        .o_reclaimed     (o_reclaimed),
        .o_too_large     (o_too_large)
    );

    // Free-running clock with a 4 ns period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_allocs.size());
            $display("** hashed_segment_bump_allocator: FAILED **");
            $finish;
        end
    end

    // Predict the response of one request and update the fill table.
    function automatic t_alloc_resp place_request(input logic [HSBA_SIZE_W-1:0] size,
                                                  input logic [HSBA_HASH_W-1:0] hash);
        t_alloc_resp resp;
        int unsigned home;
        int unsigned seg;
        bit          placed;
        resp = '0;
        if (size > SEG_BYTES) begin
            resp.too_large = 1'b1;
            oversize_count++;
            return resp;
        end
        if (size == 0)
            zero_size_count++;
        home   = hash % SEGS;
        seg    = home;
        placed = (SEG_BYTES - fill_level[home]) >= size;
        // Probe the following segments in order, wrapping around.
        for (int i = 1; i <= NUM_PROBES && !placed; i++) begin
            seg    = (home + i) % SEGS;
            placed = (SEG_BYTES - fill_level[seg]) >= size;
        end
        if (placed) begin
            resp.offset = fill_level[seg][HSBA_OFF_W-1:0];
            fill_level[seg] = fill_level[seg] + size;
            if (seg != home)
                neighbor_count++;
        end else begin
            // No room anywhere nearby: the home segment starts over.
            seg = home;
            fill_level[seg] = size;
            resp.reclaimed = 1'b1;
            reclaim_count++;
        end
        resp.segment_index = seg[HSBA_IDX_W-1:0];
        return resp;
    endfunction

    // Count one mismatch and print it while the count is within MAX_PRINTS.
    task automatic report_mismatch(input string what, input longint exp_val,
                                   input longint got_val);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH %s: expected %0h, got %0h", $time, what,
                     exp_val, got_val);
    endtask

    // Compare each response transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_alloc_resp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_allocs.size() == 0) begin
                report_mismatch("unexpected response", 0, 1);
            end else begin
                want = pending_allocs.pop_front();
                checked_count++;
                if (o_segment_index !== want.segment_index)
                    report_mismatch("segment_index", want.segment_index, o_segment_index);
                if (o_offset !== want.offset)
                    report_mismatch("offset", want.offset, o_offset);
                if (o_reclaimed !== want.reclaimed)
                    report_mismatch("reclaimed", want.reclaimed, o_reclaimed);
                if (o_too_large !== want.too_large)
                    report_mismatch("too_large", want.too_large, o_too_large);
            end
        end
    end

    // Receiver back-pressure: changing patterns, plus an on-demand long hold-off.
    always @(negedge i_clk) begin
        if (holdoff_request) begin
            holdoff_left    = HOLDOFF_CYCLES;
            holdoff_request = 1'b0;
        end
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        if (drain_flush || !i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holdoff_left > 0) begin
            i_stall <= 1'b1;
            holdoff_left--;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
                default:     i_stall <= (mode_left % 3 == 0);
            endcase
        end
    end

    // Offer one request transaction and hold it until it is accepted.
    task automatic send_request(input logic [HSBA_SIZE_W-1:0] size,
                                input logic [HSBA_HASH_W-1:0] hash);
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_request_size <= size;
        i_hash         <= hash;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_allocs.push_back(place_request(size, hash));
    endtask

    // Leave the input channel idle for a number of cycles.
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Stop sending and wait until every predicted response has been checked.
    task automatic wait_until_drained();
        idle_sender(1);
        while (pending_allocs.size() != 0)
            @(posedge i_clk);
    endtask

    // Zero-size requests, a request that fills a segment exactly, and a spill.
    task automatic test_zero_and_full_segment();
        send_request(21'd0, 32'h0000_0000);
        send_request(21'(SEG_BYTES), 32'hFFFF_FFF0);
        // The home segment is now full; a zero-size request still lands there.
        send_request(21'd0, 32'h0000_0010);
        send_request(21'd1, 32'h8000_0000);
    endtask

    // Oversized requests are flagged, table unchanged; a full-segment one is not.
    task automatic test_oversized();
        send_request(21'(SEG_BYTES + 1), 32'hFFFF_FFFF);
        send_request(21'h1F_FFFF, 32'h5555_5555);
        send_request(21'(SEG_BYTES), 32'hAAAA_AAAF);
    endtask

    // Probing wraps from the last segment to the first ones.
    task automatic test_probe_and_wrap();
        send_request(21'(SEG_BYTES), 32'h0000_000F);
        // All four candidates are now full or partly used: home is reclaimed.
        send_request(21'(SEG_BYTES), 32'h1234_567F);
    endtask

    // Fill a home segment and its neighbors, then force a reclaim.
    task automatic test_reclaim();
        for (int seg = 4; seg < 8; seg++)
            send_request(21'(SEG_BYTES), HSBA_HASH_W'(seg));
        send_request(21'd1, 32'hDEAD_BEE4);
        send_request(21'd1, 32'h0000_0004);
        send_request(21'(SEG_BYTES - 1), 32'h0000_0004);
        send_request(21'd0, 32'h7FFF_FFF4);
    endtask

    // Pick a request size, weighted toward sizes that drive probing and reclaim.
    function automatic logic [HSBA_SIZE_W-1:0] pick_size(input int unsigned home);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        if (roll < 8)
            return HSBA_SIZE_W'($urandom_range(SEG_BYTES + 1, (1 << HSBA_SIZE_W) - 1));
        if (roll < 14)
            return HSBA_SIZE_W'(SEG_BYTES - fill_level[home]);
        if (roll < 24)
            return HSBA_SIZE_W'($urandom_range(SEG_BYTES / 2, SEG_BYTES));
        if (roll < 50)
            return HSBA_SIZE_W'($urandom_range(4096, SEG_BYTES / 4));
        return HSBA_SIZE_W'($urandom_range(1, 4096));
    endfunction

    // Pick a hash; some of them aim at a few hot segments to build up contention.
    function automatic logic [HSBA_HASH_W-1:0] pick_hash();
        logic [HSBA_HASH_W-1:0] hash;
        hash = $urandom();
        if ($urandom_range(0, 9) < 3)
            hash[HSBA_IDX_W-1:0] = ($urandom_range(0, 1) != 0) ? HSBA_IDX_W'($urandom_range(0, 3))
                                                                 : HSBA_IDX_W'($urandom_range(12, 15));
        return hash;
    endfunction

    // Random requests sent in bursts with random gaps between them.
    task automatic test_random_mix(input int count);
        int                     burst_left;
        logic [HSBA_HASH_W-1:0] hash;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 8));
            end
            burst_left--;
            hash = pick_hash();
            send_request(pick_size(hash % SEGS), hash);
        end
    endtask

    // Hold off the receiver for a long stretch while requests keep coming.
    task automatic test_output_holdoff();
        logic [HSBA_HASH_W-1:0] hash;
        holdoff_request = 1'b1;
        for (int n = 0; n < 30; n++) begin
            hash = pick_hash();
            send_request(pick_size(hash % SEGS), hash);
        end
    endtask

    // Let the block empty completely, then resume traffic.
    task automatic test_pause_until_empty();
        logic [HSBA_HASH_W-1:0] hash;
        for (int round = 0; round < 2; round++) begin
            for (int n = 0; n < 20; n++) begin
                hash = pick_hash();
                send_request(pick_size(hash % SEGS), hash);
            end
            wait_until_drained();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_request_size  = '0;
        i_hash          = '0;
        i_stall         = 1'b0;
        error_count     = 0;
        checked_count   = 0;
        cycle_count     = 0;
        neighbor_count  = 0;
        reclaim_count   = 0;
        oversize_count  = 0;
        zero_size_count = 0;
        stall_mode      = STALL_NONE;
        mode_left       = 0;
        holdoff_left    = 0;
        holdoff_request = 1'b0;
        drain_flush     = 1'b0;
        for (int seg = 0; seg < SEGS; seg++)
            fill_level[seg] = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_and_full_segment();
        test_oversized();
        test_probe_and_wrap();
        test_reclaim();
        test_random_mix(RANDOM_ITEMS / 2);
        test_output_holdoff();
        test_pause_until_empty();
        test_random_mix(RANDOM_ITEMS / 2);

        // Final drain with the receiver always ready.
        drain_flush = 1'b1;
        wait_until_drained();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d responses: %0d neighbor placements, %0d reclaims,",
                 checked_count, neighbor_count, reclaim_count);
        $display("%0d oversized and %0d zero-size requests, with stalls on both sides.",
                 oversize_count, zero_size_count);
        if (error_count == 0) begin
            $display("** hashed_segment_bump_allocator: PASSED **");
        end else begin
            $display("%0d mismatches", error_count);
            $display("** hashed_segment_bump_allocator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hsba_pkg.sv
rtl/hsba_home.sv
rtl/hashed_segment_bump_allocator.sv
rtl/hsba_checker.sv
dv/tb_top.sv
